>>> hdl/smm_pkg.sv
// Shared constants, control word type and microcode table for the square matrix multiplier.
// No dependencies; imported by smm_ram users and square_matrix_multiply_core.
package smm_pkg;

   // Matrix geometry
   localparam int MAX_SIZE = 8;
   localparam int IDX_W    = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
   localparam int CNT_W    = $clog2(MAX_SIZE + 1);
   localparam int DEPTH    = MAX_SIZE * MAX_SIZE;
   localparam int ADDR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   // Field widths
   localparam int ROW_W   = 3;
   localparam int VALUE_W = 16;
   localparam int SIZE_W  = 4;
   localparam int PROD_W  = 2 * VALUE_W;
   localparam int ACC_W   = 40;

   localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(MAX_SIZE);

   // Step counter
   localparam int PC_W = 3;
   localparam logic [PC_W-1:0] STEP_IDLE  = 3'd0;
   localparam logic [PC_W-1:0] STEP_INIT  = 3'd1;
   localparam logic [PC_W-1:0] STEP_ISSUE = 3'd2;
   localparam logic [PC_W-1:0] STEP_MUL   = 3'd3;
   localparam logic [PC_W-1:0] STEP_ACC   = 3'd4;
   localparam logic [PC_W-1:0] STEP_EMIT  = 3'd5;
   localparam logic [PC_W-1:0] STEP_NEXT  = 3'd6;

   // Jump conditions
   localparam int COND_W = 3;
   localparam logic [COND_W-1:0] COND_NEVER    = 3'd0;
   localparam logic [COND_W-1:0] COND_ALWAYS   = 3'd1;
   localparam logic [COND_W-1:0] COND_NO_START = 3'd2;
   localparam logic [COND_W-1:0] COND_K_MORE   = 3'd3;
   localparam logic [COND_W-1:0] COND_LAST     = 3'd4;

   typedef struct packed {
      logic              clr_ij;   // reset row/col counters
      logic              clr_k;    // reset k counter and accumulator
      logic              mul_en;   // register the product of the read data
      logic              acc_en;   // add product into accumulator, bump k
      logic              emit;     // load output register, step row/col
      logic              wait_out; // hold this step while output is full
      logic [COND_W-1:0] cond;
      logic [PC_W-1:0]   target;
   } ucode_type;

   function automatic ucode_type smm_ucode(input logic [PC_W-1:0] pc);
      ucode_type w;
      w = '0;
      case (pc)
         STEP_IDLE: begin
            w.cond   = COND_NO_START;
            w.target = STEP_IDLE;
         end
         STEP_INIT: begin
            w.clr_ij = 1'b1;
            w.clr_k  = 1'b1;
         end
         STEP_ISSUE: begin
            w.cond = COND_NEVER;
         end
         STEP_MUL: begin
            w.mul_en = 1'b1;
         end
         STEP_ACC: begin
            w.acc_en = 1'b1;
            w.cond   = COND_K_MORE;
            w.target = STEP_ISSUE;
         end
         STEP_EMIT: begin
            w.emit     = 1'b1;
            w.wait_out = 1'b1;
            w.cond     = COND_LAST;
            w.target   = STEP_IDLE;
         end
         STEP_NEXT: begin
            w.clr_k  = 1'b1;
            w.cond   = COND_ALWAYS;
            w.target = STEP_ISSUE;
         end
         default: begin
            w.cond   = COND_ALWAYS;
            w.target = STEP_IDLE;
         end
      endcase
      return w;
   endfunction

endpackage

>>> hdl/smm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module smm_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     write_enable,
   input  logic [$clog2(DEPTH)-1:0] write_address,
   input  logic [WIDTH-1:0]         write_data,
   input  logic [$clog2(DEPTH)-1:0] read_address,
   output logic [WIDTH-1:0]         read_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem_ff[write_address] <= write_data;
      end
      read_data_ff <= mem_ff[read_address];
   end

   assign read_data = read_data_ff;

endmodule

>>> hdl/square_matrix_multiply_core.sv
// Top level of the square matrix multiplier: microcoded sequencer, MAC datapath, output register.
// Depends on smm_pkg and smm_ram.
//
// Usage:
//   req_* channel loads one matrix element per transfer (kind 0 = A, 1 = B, row, col,
//   value). A transfer with req_start_req set stores its element and then starts C = A x B
//   over the active size n (csr register, 0 acts as 1, above 8 acts as 8).
//   rsp_* channel returns the n*n elements of C in row-major order, rsp_last on the final one.
//   Loads are taken one per cycle while the sequencer is idle; req_stall is high for the
//   whole product computation.
//   Each element of C is built by one multiply-accumulate pass per k (RAM read, multiply,
//   add through the one MAC unit and the single read port of each store) plus an emit step
//   and one setup step.
//   A finished element sits in the output register; if rsp_stall holds it there the sequencer
//   waits in its emit step, and the next load can be taken once the last element is loaded
//   into the output register.
//   Reset (synchronous) returns to idle, empties the output register and sets the size to 8.
//   Matrix stores are not cleared; entries must be written before they are used.
module square_matrix_multiply_core (
   input  logic                         clock,
   input  logic                         reset,
   // load channel
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_kind,
   input  logic [smm_pkg::ROW_W-1:0]    req_row,
   input  logic [smm_pkg::ROW_W-1:0]    req_col,
   input  logic signed [smm_pkg::VALUE_W-1:0] req_value,
   input  logic                         req_start_req,
   // result channel
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [smm_pkg::ROW_W-1:0]    rsp_out_row,
   output logic [smm_pkg::ROW_W-1:0]    rsp_out_col,
   output logic signed [smm_pkg::ACC_W-1:0] rsp_product,
   output logic                         rsp_last,
   // configuration
   input  logic                         csr_write_enable,
   input  logic [smm_pkg::SIZE_W-1:0]   csr_write_data
);
   import smm_pkg::*;

   // ---------------------------------------------------------------- config
   logic [SIZE_W-1:0] active_size_ff, active_size_in;
   logic [CNT_W-1:0]  n;

   always_comb begin
      active_size_in = csr_write_enable ? csr_write_data : active_size_ff;
   end

   // saturate the size into 1..MAX_SIZE
   always_comb begin
      if (active_size_ff == '0) begin
         n = CNT_W'(1);
      end else if (active_size_ff > SIZE_W'(MAX_SIZE)) begin
         n = CNT_W'(MAX_SIZE);
      end else begin
         n = CNT_W'(active_size_ff);
      end
   end

   // ---------------------------------------------------------------- sequencer
   logic [PC_W-1:0]  pc_ff, pc_in;
   ucode_type        uc;
   logic             req_accept;
   logic             out_busy;
   logic             hold;
   logic             cond_true;
   logic             last_elem;
   logic             rsp_valid_ff, rsp_valid_in;

   logic [CNT_W-1:0] i_ff, i_in;
   logic [CNT_W-1:0] j_ff, j_in;
   logic [CNT_W-1:0] k_ff, k_in;
   logic [CNT_W-1:0] k_plus;
   logic [CNT_W-1:0] j_plus;

   assign uc         = smm_ucode(pc_ff);
   assign req_stall  = (pc_ff != STEP_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign out_busy   = rsp_valid_ff && rsp_stall;
   assign hold       = uc.wait_out && out_busy;
   assign k_plus     = k_ff + CNT_W'(1);
   assign j_plus     = j_ff + CNT_W'(1);
   assign last_elem  = (i_ff == n - CNT_W'(1)) && (j_ff == n - CNT_W'(1));

   always_comb begin
      case (uc.cond)
         COND_NEVER:    cond_true = 1'b0;
         COND_ALWAYS:   cond_true = 1'b1;
         COND_NO_START: cond_true = !(req_accept && req_start_req);
         COND_K_MORE:   cond_true = (k_plus != n);
         COND_LAST:     cond_true = last_elem;
         default:       cond_true = 1'b0;
      endcase
   end

   always_comb begin
      if (hold) begin
         pc_in = pc_ff;
      end else if (cond_true) begin
         pc_in = uc.target;
      end else begin
         pc_in = pc_ff + PC_W'(1);
      end
   end

   // loop counters
   always_comb begin
      i_in = i_ff;
      j_in = j_ff;
      k_in = k_ff;
      if (uc.clr_ij) begin
         i_in = '0;
         j_in = '0;
      end else if (uc.emit && !hold) begin
         if (j_plus == n) begin
            j_in = '0;
            i_in = i_ff + CNT_W'(1);
         end else begin
            j_in = j_plus;
         end
      end
      if (uc.clr_k) begin
         k_in = '0;
      end else if (uc.acc_en) begin
         k_in = k_plus;
      end
   end

   // ---------------------------------------------------------------- stores
   logic [ADDR_W-1:0]       wr_addr;
   logic                    wr_in_range;
   logic                    left_we, right_we;
   logic [ADDR_W-1:0]       left_raddr, right_raddr;
   logic [VALUE_W-1:0]      left_rdata, right_rdata;

   assign wr_addr      = ADDR_W'(req_row) * ADDR_W'(MAX_SIZE) + ADDR_W'(req_col);
   assign wr_in_range  = (32'(req_row) < MAX_SIZE) && (32'(req_col) < MAX_SIZE);
   assign left_we      = req_accept && wr_in_range && !req_kind;
   assign right_we     = req_accept && wr_in_range && req_kind;

   // A[i][k] and B[k][j]
   assign left_raddr  = ADDR_W'(i_ff[IDX_W-1:0]) * ADDR_W'(MAX_SIZE) + ADDR_W'(k_ff[IDX_W-1:0]);
   assign right_raddr = ADDR_W'(k_ff[IDX_W-1:0]) * ADDR_W'(MAX_SIZE) + ADDR_W'(j_ff[IDX_W-1:0]);

   smm_ram #(.WIDTH(VALUE_W), .DEPTH(DEPTH)) u_left_ram (
      .clock         (clock),
      .write_enable  (left_we),
      .write_address (wr_addr),
      .write_data    (req_value),
      .read_address  (left_raddr),
      .read_data     (left_rdata)
   );

   smm_ram #(.WIDTH(VALUE_W), .DEPTH(DEPTH)) u_right_ram (
      .clock         (clock),
      .write_enable  (right_we),
      .write_address (wr_addr),
      .write_data    (req_value),
      .read_address  (right_raddr),
      .read_data     (right_rdata)
   );

   // ---------------------------------------------------------------- MAC
   logic signed [VALUE_W-1:0] a_data, b_data;
   logic signed [PROD_W-1:0]  prod_ff, prod_in;
   logic signed [ACC_W-1:0]   acc_ff, acc_in;

   assign a_data = left_rdata;
   assign b_data = right_rdata;

   always_comb begin
      prod_in = uc.mul_en ? a_data * b_data : prod_ff;
      if (uc.clr_k) begin
         acc_in = '0;
      end else if (uc.acc_en) begin
         acc_in = acc_ff + ACC_W'(prod_ff);
      end else begin
         acc_in = acc_ff;
      end
   end

   // ---------------------------------------------------------------- output register
   logic                    out_load;
   logic [ROW_W-1:0]        out_row_ff, out_row_in;
   logic [ROW_W-1:0]        out_col_ff, out_col_in;
   logic signed [ACC_W-1:0] product_ff, product_in;
   logic                    last_ff, last_in;

   assign out_load = uc.emit && !hold;

   always_comb begin
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
      out_row_in = out_load ? ROW_W'(i_ff) : out_row_ff;
      out_col_in = out_load ? ROW_W'(j_ff) : out_col_ff;
      product_in = out_load ? acc_ff       : product_ff;
      last_in    = out_load ? last_elem    : last_ff;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_out_row = out_row_ff;
   assign rsp_out_col = out_col_ff;
   assign rsp_product = product_ff;
   assign rsp_last    = last_ff;

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff          <= STEP_IDLE;
         rsp_valid_ff   <= 1'b0;
         active_size_ff <= SIZE_RESET;
      end else begin
         pc_ff          <= pc_in;
         rsp_valid_ff   <= rsp_valid_in;
         active_size_ff <= active_size_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff       <= i_in;
      j_ff       <= j_in;
      k_ff       <= k_in;
      prod_ff    <= prod_in;
      acc_ff     <= acc_in;
      out_row_ff <= out_row_in;
      out_col_ff <= out_col_in;
      product_ff <= product_in;
      last_ff    <= last_in;
   end

   // ---------------------------------------------------------------- assertions
   // final element sits on the diagonal
   a_last_diag: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last) |-> (rsp_out_row == rsp_out_col))
      else $error("last flag off the diagonal");

   // accumulate only follows a multiply step
   a_acc_after_mul: assert property (@(posedge clock) disable iff (reset)
      (pc_ff == STEP_ACC) |-> ($past(pc_ff) == STEP_MUL))
      else $error("accumulate without multiply");

   // start transfer launches the sequencer
   a_start_launch: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_start_req) |=> (pc_ff == STEP_INIT))
      else $error("start transfer did not launch");

   // read index stays inside the active size
   a_k_range: assert property (@(posedge clock) disable iff (reset)
      (pc_ff == STEP_ISSUE) |-> (k_ff < n && i_ff < n && j_ff < n))
      else $error("loop index out of range");

endmodule
